// ===== rtl/urlpd_pkg.sv =====
package urlpd_pkg;

  // Decoder mode codes
  localparam logic [1:0] MODE_IDLE = 2'd0;  // no escape pending
  localparam logic [1:0] MODE_PCT  = 2'd1;  // '%' seen
  localparam logic [1:0] MODE_DIG  = 2'd2;  // '%' and one hex digit seen

  // Character codes
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Results one input byte can cause at most
  localparam int MAX_RES = 3;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;
  } out_item_t;

  // One queued input: its result bytes, how many, and end-of-string mark
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    last;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd97 && c <= 8'd102) ||
             (c >= 8'd65 && c <= 8'd70);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      t = c - 8'd48;
    end else if (c >= 8'd97 && c <= 8'd102) begin
      t = c - 8'd87;
    end else if (c >= 8'd65 && c <= 8'd70) begin
      t = c - 8'd55;
    end
    hex_val = t[3:0];
  endfunction

  // Decoded values that stay escaped: digits, letters, reserved symbols
  function automatic logic passes_through(input logic [7:0] v);
    passes_through = (v >= 8'd48 && v <= 8'd57) || (v >= 8'd97 && v <= 8'd122) ||
                     (v >= 8'd65 && v <= 8'd90) || v == 8'h21 || v == 8'h24 ||
                     (v >= 8'h26 && v <= 8'h2F) || v == 8'h3A || v == 8'h3B ||
                     v == 8'h3D || v == 8'h3F || v == 8'h40 || v == 8'h5F;
  endfunction

endpackage

// ===== rtl/url_percent_decoder.sv =====
// URL percent decoder.
// Input channel in_valid/in_ready/in_data carries one encoded byte per
// transfer, with in_last on the final byte of a string. Output channel
// out_valid/out_ready/out_data carries decoded bytes; run_last marks the last
// result of one input byte, stream_last the final result of a string.
// '+' becomes a space; '%' plus two hex digits becomes the decoded byte unless
// that byte is a letter, digit or reserved symbol, in which case the escape is
// passed on literally. A pending escape is flushed at in_last.
// Each input byte yields zero to three results. The front classifies a byte in
// the cycle it is taken and queues its results; the back hands out one result
// per cycle while the receiver accepts, from a registered output stage. The first
// result of a byte passes through the queue and the output register. Input runs
// at one byte per cycle as long as the result rate keeps up; inputs that expand
// to several bytes fill the queue (QDEPTH entries) and then hold in_ready low.
// A stalled receiver backs the queue up; nothing is lost or repeated.
// Reset clears the escape state, the queue and the output valid flag.
module url_percent_decoder #(
  parameter int QDEPTH = urlpd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  urlpd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output urlpd_pkg::out_item_t out_data
);
  import urlpd_pkg::*;

  logic             cmd_wr, cmd_full, cmd_rd, cmd_empty;
  cmd_t             cmd_in, cmd_out;
  logic [CMD_W-1:0] cmd_out_bits;

  assign cmd_out = cmd_t'(cmd_out_bits);

  urlpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_wr   (cmd_wr),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  urlpd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out_bits),
    .empty   (cmd_empty)
  );

  urlpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/urlpd_front.sv =====
module urlpd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  urlpd_pkg::in_item_t in_data,
  output logic              cmd_wr,
  output urlpd_pkg::cmd_t   cmd_data,
  input  logic              cmd_full
);
  import urlpd_pkg::*;

  logic [1:0]              mode_r, mode_nxt;
  logic [7:0]              held_r, held_nxt;
  logic [MAX_RES-1:0][7:0] e;
  logic [1:0]              n;
  logic                    do_idle;
  logic [7:0]              b;
  logic [7:0]              v;
  logic                    xfer;

  assign b        = in_data.in_byte;
  assign in_ready = !cmd_full;
  assign xfer     = in_valid && in_ready;

  // Classify the byte against the pending escape
  always_comb begin
    e        = '0;
    n        = 2'd0;
    mode_nxt = mode_r;
    held_nxt = held_r;
    do_idle  = 1'b0;
    v        = {hex_val(held_r), hex_val(b)};
    unique case (mode_r)
      MODE_PCT: begin
        if (is_hex(b)) begin
          held_nxt = b;
          mode_nxt = MODE_DIG;
        end else begin
          e[0]     = CH_PERCENT;
          n        = 2'd1;
          mode_nxt = MODE_IDLE;
          do_idle  = 1'b1;
        end
      end
      MODE_DIG: begin
        mode_nxt = MODE_IDLE;
        if (is_hex(b)) begin
          if (!passes_through(v)) begin
            e[0] = v;
            n    = 2'd1;
          end else begin
            e[0] = CH_PERCENT;
            e[1] = held_r;
            e[2] = b;
            n    = 2'd3;
          end
        end else begin
          e[0]    = CH_PERCENT;
          e[1]    = held_r;
          n       = 2'd2;
          do_idle = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        do_idle  = 1'b1;
      end
    endcase

    // Plain byte handling in idle mode
    if (do_idle) begin
      if (b == CH_PLUS) begin
        e[n] = CH_SPACE;
        n    = n + 2'd1;
      end else if (b == CH_PERCENT) begin
        mode_nxt = MODE_PCT;
      end else begin
        e[n] = b;
        n    = n + 2'd1;
      end
    end

    // End of string: flush what is pending
    if (in_data.in_last) begin
      if (mode_nxt == MODE_PCT) begin
        e[n] = CH_PERCENT;
        n    = n + 2'd1;
      end else if (mode_nxt == MODE_DIG) begin
        e[n]              = CH_PERCENT;
        e[2'(n + 2'd1)]   = held_nxt;
        n                 = n + 2'd2;
      end
      mode_nxt = MODE_IDLE;
    end
  end

  assign cmd_wr        = xfer && (n != 2'd0);
  assign cmd_data.bytes = e;
  assign cmd_data.cnt   = n;
  assign cmd_data.last  = in_data.in_last;

  // Escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      held_r <= 8'd0;
    end else if (xfer) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== rtl/urlpd_fifo.sv =====
module urlpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/urlpd_back.sv =====
module urlpd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  urlpd_pkg::cmd_t      cmd_data,
  input  logic                 cmd_empty,
  output logic                 cmd_rd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output urlpd_pkg::out_item_t out_data
);
  import urlpd_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_r;
  logic       load;
  logic       take;
  logic       fin;

  assign load   = !out_valid_r || out_ready;
  assign take   = load && !cmd_empty;
  assign fin    = (idx_r == 2'(cmd_data.cnt - 2'd1));
  assign cmd_rd = take && fin;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Output register, one result byte per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (take) begin
      out_valid_r <= 1'b1;
      idx_r       <= fin ? 2'd0 : idx_r + 2'd1;
    end else if (load) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r.out_byte    <= cmd_data.bytes[idx_r];
      out_r.run_last    <= fin;
      out_r.stream_last <= fin && cmd_data.last;
    end
  end

endmodule

// ===== test/url_percent_decoder_test.sv =====
module url_percent_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import urlpd_pkg::*;

  // Tracks the decoder's escape state and the decoded bytes still owed
  class decode_scoreboard;
    out_item_t  expected_q[$];
    logic [7:0] run_bytes[$];
    logic [1:0] mode;
    logic [7:0] held;
    int         mismatches;
    int         results_seen;
    int         inputs_seen;
    int         strings_seen;

    function new();
      mode = MODE_IDLE;
      held = 8'h00;
      mismatches = 0;
      results_seen = 0;
      inputs_seen = 0;
      strings_seen = 0;
    endfunction

    // -1 when c is not a hex digit
    function int hex_nibble(logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) begin
        return c - 8'h30;
      end
      if (c inside {[8'h41:8'h46]}) begin
        return c - 8'h41 + 10;
      end
      if (c inside {[8'h61:8'h66]}) begin
        return c - 8'h61 + 10;
      end
      return -1;
    endfunction

    // decoded values that must stay escaped
    function bit kept_escaped(logic [7:0] v);
      return v inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h21, 8'h24,
                       [8'h26:8'h2F], 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5F};
    endfunction

    // byte seen with no escape pending
    function void plain_byte(logic [7:0] b);
      if (b == CH_PLUS) begin
        run_bytes.push_back(CH_SPACE);
      end else if (b == CH_PERCENT) begin
        mode = MODE_PCT;
      end else begin
        run_bytes.push_back(b);
      end
    endfunction

    function void note_input(in_item_t it);
      int        hi;
      int        lo;
      out_item_t r;
      logic [7:0] v;
      run_bytes.delete();
      inputs_seen++;
      case (mode)
        MODE_PCT: begin
          if (hex_nibble(it.in_byte) >= 0) begin
            held = it.in_byte;
            mode = MODE_DIG;
          end else begin
            run_bytes.push_back(CH_PERCENT);
            mode = MODE_IDLE;
            plain_byte(it.in_byte);
          end
        end
        MODE_DIG: begin
          hi = hex_nibble(held);
          lo = hex_nibble(it.in_byte);
          mode = MODE_IDLE;
          if (hi >= 0 && lo >= 0) begin
            v = {hi[3:0], lo[3:0]};
            if (!kept_escaped(v)) begin
              run_bytes.push_back(v);
            end else begin
              run_bytes.push_back(CH_PERCENT);
              run_bytes.push_back(held);
              run_bytes.push_back(it.in_byte);
            end
          end else begin
            // broken escape after one digit
            run_bytes.push_back(CH_PERCENT);
            run_bytes.push_back(held);
            plain_byte(it.in_byte);
          end
        end
        default: begin
          mode = MODE_IDLE;
          plain_byte(it.in_byte);
        end
      endcase
      // end of string flushes whatever escape is pending
      if (it.in_last) begin
        if (mode == MODE_PCT) begin
          run_bytes.push_back(CH_PERCENT);
        end else if (mode == MODE_DIG) begin
          run_bytes.push_back(CH_PERCENT);
          run_bytes.push_back(held);
        end
        mode = MODE_IDLE;
        strings_seen++;
      end
      foreach (run_bytes[i]) begin
        r.out_byte = run_bytes[i];
        r.run_last = (i == run_bytes.size() - 1);
        r.stream_last = r.run_last & it.in_last;
        expected_q.push_back(r);
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, byte %02h", got.out_byte));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        report($sformatf("out_byte %02h, wanted %02h", got.out_byte, want.out_byte));
      end
      if (got.run_last !== want.run_last) begin
        report($sformatf("run_last %b, wanted %b (byte %02h)", got.run_last,
                         want.run_last, want.out_byte));
      end
      if (got.stream_last !== want.stream_last) begin
        report($sformatf("stream_last %b, wanted %b (byte %02h)", got.stream_last,
                         want.stream_last, want.out_byte));
      end
    endtask

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  decode_scoreboard sb = new();

  url_percent_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // one input transfer, with optional idle cycles ahead of it
  task send_byte(logic [7:0] b, bit last);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    items_sent++;
  endtask

  task send_text(string s, bit last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  // hold off the sender until every owed result is out
  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function bit rand_last();
    return $urandom_range(0, 15) == 0;
  endfunction

  function logic [7:0] hex_char();
    int n;
    n = $urandom_range(0, 15);
    if (n < 10) begin
      return 8'(8'h30 + n);
    end
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 10);
  endfunction

  function logic [7:0] non_hex_char();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: c = CH_PERCENT;
      1: c = CH_PLUS;
      default: begin
        do c = 8'($urandom_range(0, 255)); while (sb.hex_nibble(c) >= 0);
      end
    endcase
    return c;
  endfunction

  // well-formed escapes in two of five picks, plus literals and broken sequences
  task send_random_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_byte(CH_PERCENT, rand_last());
      send_byte(hex_char(), rand_last());
      send_byte(hex_char(), rand_last());
    end else if (pick < 65) begin
      send_byte(8'($urandom_range(0, 255)), rand_last());
    end else if (pick < 72) begin
      send_byte(CH_PLUS, rand_last());
    end else if (pick < 82) begin
      send_byte(CH_PERCENT, rand_last());
      send_byte(non_hex_char(), rand_last());
    end else if (pick < 92) begin
      send_byte(CH_PERCENT, rand_last());
      send_byte(hex_char(), rand_last());
      send_byte(non_hex_char(), rand_last());
    end else if ($urandom_range(0, 1)) begin
      // string ends right on the '%'
      send_byte(CH_PERCENT, 1'b1);
    end else begin
      send_byte(CH_PERCENT, 1'b0);
      send_byte(hex_char(), 1'b1);
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, decoded and kept escapes, broken escapes, flushes
    send_text("+", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("%20", 1'b0);
    send_text("%41", 1'b0);
    send_text("%fF", 1'b0);
    send_text("%Z", 1'b0);
    send_text("%4g", 1'b0);
    send_text("%%25", 1'b0);
    send_text("%", 1'b1);
    send_text("%7", 1'b1);
    send_text("x", 1'b1);
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      target = items_sent + 110;
      while (items_sent < target) begin
        send_random_token();
      end
      drain();
    end

    // settle and catch any stray results
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("covered %0d input transfers over %0d strings, %0d result transfers checked",
             sb.inputs_seen, sb.strings_seen, sb.results_seen);
    $display("idle phases: none, sender gaps, receiver stalls, both; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== url_percent_decoder.f =====
rtl/urlpd_pkg.sv
rtl/urlpd_front.sv
rtl/urlpd_fifo.sv
rtl/urlpd_back.sv
rtl/url_percent_decoder.sv
test/url_percent_decoder_test.sv
